>>> src/hlru_pkg.sv
// Shared types, codes and helpers for the hashed LRU buffer cache.
// No dependencies; every other file imports this package.
package hlru_pkg;

  localparam int SETS           = 16;
  localparam int SET_W          = $clog2(SETS);
  localparam int WAYS_DEF       = 4;
  localparam int DATA_BYTES_DEF = 8;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_TOO_LONG    = 3'd3,
    ST_ZERO_INSERT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] class_id;
    logic [3:0]  length;
    logic [63:0] write_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

>>> src/hlru_ctrl.sv
// Request sequencer for the hashed LRU buffer cache.
// Depends on hlru_pkg; drives commands into hlru_dp.
module hlru_ctrl import hlru_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_stall_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat_i.out_full) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

>>> src/hlru_dp.sv
// Datapath of the hashed LRU buffer cache: row memory, valid bits,
// hit logic, recency update and response register. Depends on hlru_pkg.
module hlru_dp import hlru_pkg::*; #(
  parameter int WAYS       = WAYS_DEF,
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  input  req_t  in_req_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output rsp_t  out_rsp_o,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i
);

  localparam int AGE_W = (WAYS > 2) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int WAY_W = $clog2(WAYS);

  typedef struct packed {
    logic [63:0]      key;
    logic [63:0]      cls;
    logic [3:0]       len;
    logic [63:0]      bytes;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  row_t             mem [SETS];
  row_t             row_q, row_d;
  logic [WAYS-1:0]  vld_q [SETS];
  logic [WAYS-1:0]  vld_d;
  req_t             req_q;
  logic [SET_W-1:0] set_sel, set_q;
  logic             en_q, out_valid_q;
  rsp_t             rsp_q, rsp_d;

  logic [AGE_W-1:0] age_eff [WAYS];
  logic             hit, evicted, placed;
  logic [WAY_W-1:0] hw;
  logic [CNT_W-1:0] cnt, cnt_after;
  logic [AGE_W-1:0] ha;
  logic [63:0]      m;

  assign set_sel = in_req_i.key[SET_W-1:0] ^ in_req_i.class_id[SET_W-1:0];

  always_comb begin
    vld_d     = vld_q[set_q];
    row_d     = row_q;
    rsp_d     = '0;
    rsp_d.status = ST_OK;
    hit       = 1'b0;
    hw        = '0;
    cnt       = '0;
    evicted   = 1'b0;
    placed    = 1'b0;
    m         = byte_mask(req_q.length);
    for (int w = 0; w < WAYS; w++) begin
      age_eff[w] = vld_q[set_q][w] ? row_q[w].age : '0;
      row_d[w].age = age_eff[w];
      cnt = cnt + CNT_W'(vld_q[set_q][w]);
      if (!hit && vld_q[set_q][w] && row_q[w].key == req_q.key &&
          row_q[w].cls == req_q.class_id) begin
        hit = 1'b1;
        hw  = WAY_W'(w);
      end
    end
    ha = age_eff[hw];
    if (!en_q) begin
      rsp_d.status = ST_NOT_READY;
    end else begin
      case (kind_e'(req_q.kind))
        KIND_WRITE: begin
          if (req_q.length > 4'(DATA_BYTES)) begin
            rsp_d.status = ST_TOO_LONG;
          end else if (!hit) begin
            if (req_q.length == 4'd0) begin
              rsp_d.status = ST_ZERO_INSERT;
            end else begin
              if (cnt == CNT_W'(WAYS - 1)) begin
                for (int w = 0; w < WAYS; w++) begin
                  if (!evicted && vld_d[w] && age_eff[w] == AGE_W'(WAYS - 2)) begin
                    evicted      = 1'b1;
                    vld_d[w]     = 1'b0;
                    row_d[w].age = '0;
                  end
                end
              end
              for (int w = 0; w < WAYS; w++) begin
                if (vld_d[w]) begin
                  row_d[w].age = row_d[w].age + AGE_W'(1);
                end else if (!placed) begin
                  placed         = 1'b1;
                  vld_d[w]       = 1'b1;
                  row_d[w].key   = req_q.key;
                  row_d[w].cls   = req_q.class_id;
                  row_d[w].len   = req_q.length;
                  row_d[w].bytes = req_q.write_data & m;
                  row_d[w].age   = '0;
                end
              end
            end
          end else begin
            row_d[hw].bytes = (row_q[hw].bytes & ~m) | (req_q.write_data & m);
            if (req_q.length > row_q[hw].len) row_d[hw].len = req_q.length;
          end
        end
        KIND_READ: begin
          if (!hit) begin
            rsp_d.status = ST_NOT_FOUND;
          end else if (req_q.length > row_q[hw].len) begin
            rsp_d.status = ST_TOO_LONG;
          end else if (req_q.length != 4'd0) begin
            rsp_d.read_data = row_q[hw].bytes & m;
            for (int w = 0; w < WAYS; w++) begin
              if (vld_q[set_q][w] && age_eff[w] < ha) row_d[w].age = age_eff[w] + AGE_W'(1);
            end
            row_d[hw].age = '0;
          end
        end
        KIND_FLUSH: begin
          if (hit) begin
            for (int w = 0; w < WAYS; w++) begin
              if (vld_q[set_q][w] && age_eff[w] > ha) row_d[w].age = age_eff[w] - AGE_W'(1);
            end
            vld_d[hw]     = 1'b0;
            row_d[hw].age = '0;
          end
        end
        default: ;
      endcase
    end
    cnt_after = '0;
    for (int w = 0; w < WAYS; w++) cnt_after = cnt_after + CNT_W'(vld_d[w]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= mem[set_sel];
      req_q <= in_req_i;
      set_q <= set_sel;
    end
    if (cmd_i.exec) mem[set_q] <= row_d;
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) vld_q[s] <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) en_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        vld_q[set_q] <= vld_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign stat_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = rsp_q;

  a_exec_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !(out_valid_q && out_stall_i))
    else $error("response overwritten");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.exec && cmd_i.capture))
    else $error("capture during execute");
  a_set_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> cnt_after < CNT_W'(WAYS))
    else $error("set overfilled");
  a_resp_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("response lost");

endmodule

>>> src/hashed_lru_buffer_cache_unit.sv
// Top level of the hashed LRU buffer cache; joins hlru_ctrl and hlru_dp.
// Depends on hlru_pkg.
//
// Each request is first captured, which reads its set's row from the
// single-port row memory, then executed, which compares all ways, updates
// recency and writes the row back. The result is then held in an output
// register, so a new request is taken while the last result waits;
// execution pauses only while the output register is full and stalled. The
// store is valid-bit cleared at reset, so no clearing pass is needed.
module hashed_lru_buffer_cache_unit import hlru_pkg::*; #(
  parameter int WAYS       = WAYS_DEF,
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  cmd_t  cmd;
  stat_t stat;

  hlru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  hlru_dp #(
    .WAYS       (WAYS),
    .DATA_BYTES (DATA_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

>>> sim/tb_hashed_lru_buffer_cache_unit.sv
// Testbench for hashed_lru_buffer_cache_unit: directed table plus random requests,
// every response checked against an in-bench cache predictor. Depends on hlru_pkg.
module tb_hashed_lru_buffer_cache_unit;
  import hlru_pkg::*;

  localparam int NWAYS = WAYS_DEF;
  localparam int NBYTES = DATA_BYTES_DEF;
  localparam int SLOTS = SETS * NWAYS;
  localparam int RANDOM_REQS = 1230;
  localparam int IDLE_LIMIT = 5000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  req_t in_req_i;
  rsp_t out_rsp_o;
  logic cfg_we_i, cfg_wdata_i;

  hashed_lru_buffer_cache_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  logic        cache_on;
  logic        line_valid[SLOTS];
  logic [63:0] line_key[SLOTS];
  logic [63:0] line_class[SLOTS];
  logic [3:0]  line_len[SLOTS];
  logic [63:0] line_bytes[SLOTS];
  int          line_age[SLOTS];
  int          set_fill[SETS];

  rsp_t expected_rsps[$];
  int   failures = 0;
  int   checked = 0;
  int   idle_cycles = 0;
  int   reads_hit = 0;
  int   evictions = 0;

  function automatic logic [63:0] lane_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (i < n) m[i*8 +: 8] = 8'hff;
    return m;
  endfunction

  function automatic void clear_cache();
    for (int s = 0; s < SLOTS; s++) begin
      line_valid[s] = 1'b0;
      line_age[s] = 0;
    end
    for (int s = 0; s < SETS; s++) set_fill[s] = 0;
  endfunction

  function automatic void drop_line(int set, int way);
    int base, a;
    base = set * NWAYS;
    a = line_age[base + way];
    for (int w = 0; w < NWAYS; w++)
      if (line_valid[base + w] && line_age[base + w] > a) line_age[base + w]--;
    line_valid[base + way] = 1'b0;
    line_age[base + way] = 0;
    if (set_fill[set] > 0) set_fill[set]--;
  endfunction

  function automatic rsp_t cache_access(req_t r);
    rsp_t o;
    int set, base, way, s, slot, a;
    o = '0;
    set = int'((r.key ^ r.class_id) % SETS);
    base = set * NWAYS;
    way = -1;
    if (!cache_on) begin
      o.status = ST_NOT_READY;
      return o;
    end
    for (int w = NWAYS - 1; w >= 0; w--)
      if (line_valid[base + w] && line_key[base + w] == r.key &&
          line_class[base + w] == r.class_id) way = w;
    s = base + way;
    case (kind_e'(r.kind))
      KIND_WRITE: begin
        if (r.length > NBYTES) o.status = ST_TOO_LONG;
        else if (way < 0) begin
          if (r.length == 0) o.status = ST_ZERO_INSERT;
          else begin
            if (set_fill[set] >= NWAYS - 1) begin
              for (int w = 0; w < NWAYS; w++)
                if (line_valid[base + w] && line_age[base + w] == set_fill[set] - 1) begin
                  drop_line(set, w);
                  evictions++;
                  break;
                end
            end
            slot = NWAYS;
            for (int w = 0; w < NWAYS; w++) begin
              if (line_valid[base + w]) line_age[base + w]++;
              else if (slot == NWAYS) slot = w;
            end
            if (slot != NWAYS) begin
              line_valid[base + slot] = 1'b1;
              line_key[base + slot] = r.key;
              line_class[base + slot] = r.class_id;
              line_len[base + slot] = r.length;
              line_bytes[base + slot] = r.write_data & lane_mask(r.length);
              line_age[base + slot] = 0;
              set_fill[set]++;
            end
          end
        end else begin
          line_bytes[s] = (line_bytes[s] & ~lane_mask(r.length)) |
                          (r.write_data & lane_mask(r.length));
          if (r.length > line_len[s]) line_len[s] = r.length;
        end
      end
      KIND_READ: begin
        if (way < 0) o.status = ST_NOT_FOUND;
        else if (r.length > line_len[s]) o.status = ST_TOO_LONG;
        else if (r.length > 0) begin
          o.read_data = line_bytes[s] & lane_mask(r.length);
          reads_hit++;
          a = line_age[s];
          for (int w = 0; w < NWAYS; w++)
            if (line_valid[base + w] && line_age[base + w] < a) line_age[base + w]++;
          line_age[s] = 0;
        end
      end
      KIND_FLUSH: if (way >= 0) drop_line(set, way);
      default: ;
    endcase
    return o;
  endfunction

  // Receiver: stall pattern plus checking.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected response: expected none, actual %h", $time, out_rsp_o);
          failures++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          checked++;
          if (out_rsp_o.status !== e.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d", $time, e.status,
                     out_rsp_o.status);
            failures++;
          end
          if (out_rsp_o.read_data !== e.read_data) begin
            $display("%0t read_data mismatch: expected %h, actual %h", $time, e.read_data,
                     out_rsp_o.read_data);
            failures++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
      $display("FAIL");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_request(req_t r, logic check_typed, rsp_t typed);
    rsp_t p;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_req_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    p = cache_access(r);
    if (check_typed && p !== typed) begin
      $display("%0t table row disagrees with predictor: expected %h, actual %h", $time,
               typed, p);
      failures++;
    end
    expected_rsps.push_back(p);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic set_enable(logic v);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cache_on = v;
  endtask

  typedef struct {
    kind_e       kind;
    logic [63:0] key;
    logic [63:0] cls;
    logic [3:0]  len;
    logic [63:0] data;
    logic        typed;
    status_e     status;
    logic [63:0] rdata;
  } row_t;

  localparam logic [63:0] ONES = '1;
  row_t plan[] = '{
    '{KIND_WRITE, 64'h1, 64'h0, 4'd8, ONES, 1'b1, ST_NOT_READY, 64'h0},
    '{KIND_READ, 64'h1, 64'h0, 4'd1, 64'h0, 1'b1, ST_NOT_READY, 64'h0},
    '{KIND_READ, 64'h5, 64'h0, 4'd1, 64'h0, 1'b1, ST_NOT_FOUND, 64'h0},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd0, 64'h0, 1'b1, ST_ZERO_INSERT, 64'h0},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd15, ONES, 1'b1, ST_TOO_LONG, 64'h0},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd9, ONES, 1'b1, ST_TOO_LONG, 64'h0},
    '{KIND_WRITE, ONES, ONES, 4'd8, ONES, 1'b1, ST_OK, 64'h0},
    '{KIND_READ, ONES, ONES, 4'd8, 64'h0, 1'b1, ST_OK, ONES},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd2, 64'h1122_3344_5566_7788, 1'b1, ST_OK, 64'h0},
    '{KIND_READ, 64'h5, 64'h0, 4'd3, 64'h0, 1'b1, ST_TOO_LONG, 64'h0},
    '{KIND_READ, 64'h5, 64'h0, 4'd0, 64'h0, 1'b1, ST_OK, 64'h0},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd0, ONES, 1'b1, ST_OK, 64'h0},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd4, 64'hAAAA_BBBB_CCCC_DDDD, 1'b0, ST_OK, 64'h0},
    '{KIND_READ, 64'h5, 64'h0, 4'd4, 64'h0, 1'b0, ST_OK, 64'h0},
    '{KIND_WRITE, 64'h5, 64'h0, 4'd9, 64'h0, 1'b1, ST_TOO_LONG, 64'h0},
    '{KIND_WRITE, 64'h15, 64'h0, 4'd1, 64'h11, 1'b0, ST_OK, 64'h0},
    '{KIND_WRITE, 64'h25, 64'h0, 4'd1, 64'h22, 1'b0, ST_OK, 64'h0},
    '{KIND_WRITE, 64'h35, 64'h0, 4'd1, 64'h33, 1'b0, ST_OK, 64'h0},
    '{KIND_READ, 64'h5, 64'h0, 4'd1, 64'h0, 1'b1, ST_NOT_FOUND, 64'h0},
    '{KIND_READ, 64'h15, 64'h0, 4'd1, 64'h0, 1'b0, ST_OK, 64'h0},
    '{KIND_FLUSH, 64'h25, 64'h0, 4'd0, 64'h0, 1'b1, ST_OK, 64'h0},
    '{KIND_FLUSH, 64'h25, 64'h0, 4'd0, 64'h0, 1'b1, ST_OK, 64'h0},
    '{KIND_READ, 64'h25, 64'h0, 4'd1, 64'h0, 1'b1, ST_NOT_FOUND, 64'h0},
    '{KIND_NONE, ONES, 64'h0, 4'd15, ONES, 1'b1, ST_OK, 64'h0}
  };

  logic [63:0] pool_key[24];
  logic [63:0] pool_cls[24];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick, c;
    c = $urandom_range(0, 99);
    if (c < 85) begin
      pick = $urandom_range(0, 23);
      r.key = pool_key[pick];
      r.class_id = pool_cls[pick];
      c = $urandom_range(0, 99);
      r.kind = (c < 45) ? KIND_WRITE : (c < 85) ? KIND_READ : (c < 97) ? KIND_FLUSH : KIND_NONE;
      r.length = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
    end else begin
      r.key = rand64();
      r.class_id = rand64();
      r.kind = 2'($urandom_range(0, 3));
      r.length = 4'($urandom_range(0, 15));
    end
    r.write_data = rand64();
    return r;
  endfunction

  initial begin
    req_t r;
    rsp_t t;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    cache_on = 1'b0;
    clear_cache();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (i == 2) set_enable(1'b1);
      r.kind = plan[i].kind;
      r.key = plan[i].key;
      r.class_id = plan[i].cls;
      r.length = plan[i].len;
      r.write_data = plan[i].data;
      t.status = plan[i].status;
      t.read_data = plan[i].rdata;
      send_request(r, plan[i].typed, t);
    end

    for (int i = 0; i < 24; i++) begin
      pool_key[i] = (i < 4) ? ONES - i : rand64();
      pool_cls[i] = (i % 3 == 0) ? 64'h0 : rand64();
      if (i >= 12) pool_key[i] = pool_key[i - 12] ^ 64'h10 ^ {60'h0, pool_cls[i][3:0]}
                                  ^ {60'h0, pool_cls[i - 12][3:0]};
    end

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 500) set_enable(1'b0);
      if (i == 540) set_enable(1'b1);
      send_request(random_request(), 1'b0, t);
    end

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("checked %0d responses: %0d read hits, %0d evictions,", checked, reads_hit,
             evictions);
    $display("enable toggled off and on, random stall and idle patterns");
    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> hashed_lru_buffer_cache_unit.f
src/hlru_pkg.sv
src/hlru_ctrl.sv
src/hlru_dp.sv
src/hashed_lru_buffer_cache_unit.sv
sim/tb_hashed_lru_buffer_cache_unit.sv
